/* rtl/core/sme_pkg.sv */
// Shared types and constants for the stack machine executor.
// Holds operation, status and sequencer codes. Depends on nothing.
package sme_pkg;

  // Operation codes carried by the func field.
  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_HALT = 3'd4
  } op_e;

  // Status codes reported with every result item.
  typedef enum logic [2:0] {
    ST_EXECUTED  = 3'd0,
    ST_HALTED    = 3'd1,
    ST_STOPPED   = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  // Sequencer states of the core.
  typedef enum logic [1:0] {
    S_IDLE,
    S_OPERAND,
    S_WRITE,
    S_DONE
  } state_e;

  // Exit code shown until a halt sets one.
  localparam logic [7:0] EXIT_AT_RESET = 8'd123;

  // Width of the reported stack depth.
  localparam int unsigned DEPTH_W = 9;

endpackage

/* rtl/core/sme_ram.sv */
// Generic single-port RAM with a registered read port.
// Used for the word stack of the executor. Depends on nothing.
module sme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One access a cycle: a write, or a read whose data appears next cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/stack_machine_executor_core.sv */
// Stack machine executor: runs one instruction per input item on a word stack.
// Depends on sme_pkg for codes and on sme_ram for the stack memory.
//
// Usage:
//   The input channel (in_valid_i/in_ready_o) carries one instruction per
//   item: func_i selects push, add, subtract, multiply or halt, and
//   immediate_i is the word that a push places on the stack.
//   The output channel (out_valid_o/out_ready_i) returns one result item
//   per instruction: status, top of stack, stack depth and exit code.
//   The top word is held in a register; the words beneath it live in a
//   single-port RAM. A push, a no-op, a rejected item or a one-word halt
//   goes from the idle state straight to the done state; a deeper halt
//   first passes the operand read, and an arithmetic operation the
//   operand read and then the write-back on the one RAM port. The done
//   state loads the result into the output register. One instruction is in
//   work at a time; in_ready_o is high only while the sequencer is idle.
//   A finished result waits in the output register, and the next item is
//   accepted meanwhile; a further result then waits until the receiver
//   takes the first one, so a stalled receiver stalls the block.
//   Reset empties the stack, sets the exit code to 123 and starts the
//   machine running. After a halt every item is answered with the
//   already-stopped status and changes nothing.
module stack_machine_executor_core
  import sme_pkg::*;
#(
  parameter int unsigned STACK_WORDS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          func_i,
  input  logic [31:0]         immediate_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [31:0]         top_value_o,
  output logic [DEPTH_W-1:0]  stack_depth_o,
  output logic [7:0]          exit_code_o
);

  localparam int unsigned CW = $clog2(STACK_WORDS + 1);
  localparam int unsigned AW = $clog2(STACK_WORDS);
  localparam logic [CW-1:0] FULL = CW'(STACK_WORDS);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] TWO  = CW'(2);

  // Sequencer and machine state.
  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   top_q, top_d;
  logic [7:0]    exit_q, exit_d;
  logic          running_q, running_d;
  logic [2:0]    func_q, func_d;
  logic [31:0]   alu_q, alu_d;
  status_e       stat_q, stat_d;

  // Output register.
  logic          out_valid_q, out_valid_d;
  logic [2:0]    out_status_q;
  logic [31:0]   out_top_q;
  logic [DEPTH_W-1:0] out_depth_q;
  logic [7:0]    out_exit_q;

  // Stack memory port.
  logic          ram_en, ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata, ram_rdata;
  logic [31:0]   mul_lo;

  logic in_fire, out_load;
  logic is_arith, arith_read, halt_read;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Decode of the incoming item that decides whether a second word is read.
  assign is_arith   = (func_i == OP_ADD) || (func_i == OP_SUB) || (func_i == OP_MUL);
  assign arith_read = running_q && is_arith && (count_q >= TWO);
  assign halt_read  = running_q && (func_i == OP_HALT) && (count_q >= TWO);

  sme_ram #(
    .WIDTH (32),
    .DEPTH (STACK_WORDS)
  ) u_stack (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (arith_read || halt_read) ? S_OPERAND : S_DONE;
        end
      end
      S_OPERAND: begin
        state_d = (func_q == OP_HALT) ? S_DONE : S_WRITE;
      end
      S_WRITE: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Shared arithmetic unit: the top word is a, the word beneath it is b.
  // Only the low word of the product is kept, as the result wraps at 32 bits.
  assign mul_lo = top_q * ram_rdata;

  always_comb begin
    case (func_q)
      OP_ADD:  alu_d = top_q + ram_rdata;
      OP_SUB:  alu_d = top_q - ram_rdata;
      default: alu_d = mul_lo;
    endcase
  end

  // Machine state updates and stack memory control.
  always_comb begin
    count_d   = count_q;
    top_d     = top_q;
    exit_d    = exit_q;
    running_d = running_q;
    func_d    = func_q;
    stat_d    = stat_q;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = AW'(count_q - TWO);
    ram_wdata = alu_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          func_d = func_i;
          stat_d = ST_EXECUTED;
          if (!running_q) begin
            stat_d = ST_STOPPED;
          end else begin
            unique case (func_i) inside
              OP_PUSH: begin
                if (count_q >= FULL) begin
                  stat_d = ST_OVERFLOW;
                end else begin
                  ram_en    = 1'b1;
                  ram_we    = 1'b1;
                  ram_addr  = AW'(count_q);
                  ram_wdata = immediate_i;
                  top_d     = immediate_i;
                  count_d   = count_q + ONE;
                end
              end
              OP_ADD, OP_SUB, OP_MUL: begin
                if (count_q < TWO) begin
                  stat_d = ST_UNDERFLOW;
                end else begin
                  ram_en = 1'b1;
                end
              end
              OP_HALT: begin
                if (count_q == '0) begin
                  stat_d = ST_UNDERFLOW;
                end else if (count_q == ONE) begin
                  // Last word leaves the stack, no read needed.
                  exit_d    = top_q[7:0];
                  count_d   = '0;
                  running_d = 1'b0;
                  stat_d    = ST_HALTED;
                end else begin
                  ram_en = 1'b1;
                end
              end
              default: begin
                stat_d = ST_EXECUTED;
              end
            endcase
          end
        end
      end
      S_OPERAND: begin
        if (func_q == OP_HALT) begin
          // The word read beneath the top becomes the new top.
          exit_d    = top_q[7:0];
          top_d     = ram_rdata;
          count_d   = count_q - ONE;
          running_d = 1'b0;
          stat_d    = ST_HALTED;
        end
      end
      S_WRITE: begin
        // The result replaces b, and a is dropped.
        ram_en  = 1'b1;
        ram_we  = 1'b1;
        top_d   = alu_q;
        count_d = count_q - ONE;
        stat_d  = ST_EXECUTED;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // The output register is loaded when the result is done and the slot frees.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      exit_q      <= EXIT_AT_RESET;
      running_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      exit_q      <= exit_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    func_q <= func_d;
    stat_q <= stat_d;
    alu_q  <= alu_d;
    if (out_load) begin
      out_status_q <= stat_q;
      out_top_q    <= (count_q != '0) ? top_q : 32'd0;
      out_depth_q  <= DEPTH_W'(count_q);
      out_exit_q   <= exit_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign top_value_o   = out_top_q;
  assign stack_depth_o = out_depth_q;
  assign exit_code_o   = out_exit_q;

`ifndef NO_ASSERTIONS
  // The stack never holds more words than the memory has.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL)
    else $error("stack count exceeds the stack size");

  // Once halted, the machine never runs again.
  a_stays_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |=> !running_q)
    else $error("machine restarted after halt");

  // A halted result is only reported once the machine has stopped.
  a_halt_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_HALTED)) |-> !running_q)
    else $error("halt reported while the machine still runs");

  // The operand read only follows an accepted item.
  a_operand_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OPERAND) |-> $past(in_fire))
    else $error("operand state entered without an accepted item");
`endif

endmodule

/* test/tb.sv */
// Self-checking testbench for the stack machine executor core.
// Drives instruction items, predicts every result item and compares them.
// Depends on sme_pkg and stack_machine_executor_core.
module tb
  import sme_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_WORDS      = 256;
  localparam int unsigned RANDOM_PER_PHASE = 300;
  localparam int unsigned HOLD_CYCLES      = 300;
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  localparam int unsigned DRAIN_TAIL       = 20;

  // Function codes outside the defined operations; the core treats them as no-ops.
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    status_e     status;
    logic [31:0] top;
    logic [8:0]  depth;
    logic [7:0]  exit_code;
  } machine_result_t;

  typedef struct packed {
    logic [2:0]      func;
    logic [31:0]     imm;
    bit              known;
    machine_result_t res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [2:0]  func_i      = '0;
  logic [31:0] immediate_i = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [2:0]  status_o;
  logic [31:0] top_value_o;
  logic [DEPTH_W-1:0] stack_depth_o;
  logic [7:0]  exit_code_o;

  // Predicted machine state.
  logic [31:0] mach_stack [STACK_WORDS];
  int unsigned mach_count;
  logic [7:0]  mach_exit;
  bit          mach_running;

  machine_result_t pending_results [$];
  stim_row_t       directed_rows [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned holds_seen     = 0;
  int unsigned hold_left      = 0;
  int unsigned mismatches     = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent     = 0;
  int unsigned n_overflow     = 0;
  int unsigned n_underflow    = 0;
  int unsigned n_halted       = 0;

  stack_machine_executor_core #(
    .STACK_WORDS(STACK_WORDS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .immediate_i  (immediate_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .top_value_o  (top_value_o),
    .stack_depth_o(stack_depth_o),
    .exit_code_o  (exit_code_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Executes one instruction on the predicted machine and returns its result item.
  function automatic machine_result_t execute_instr(input logic [2:0] f, input logic [31:0] imm);
    machine_result_t r;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] w;
    r.status = ST_EXECUTED;
    if (!mach_running) begin
      r.status = ST_STOPPED;
    end else if (f == OP_PUSH) begin
      if (mach_count >= STACK_WORDS) begin
        r.status = ST_OVERFLOW;
      end else begin
        mach_stack[mach_count] = imm;
        mach_count++;
      end
    end else if (f == OP_ADD || f == OP_SUB || f == OP_MUL) begin
      if (mach_count < 2) begin
        r.status = ST_UNDERFLOW;
      end else begin
        a = mach_stack[mach_count-1];
        b = mach_stack[mach_count-2];
        case (f)
          OP_ADD:  w = a + b;
          OP_SUB:  w = a - b;
          default: w = a * b;
        endcase
        mach_count--;
        mach_stack[mach_count-1] = w;
      end
    end else if (f == OP_HALT) begin
      if (mach_count == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        mach_exit = mach_stack[mach_count-1][7:0];
        mach_count--;
        mach_running = 1'b0;
        r.status = ST_HALTED;
      end
    end
    r.top       = (mach_count == 0) ? 32'h0 : mach_stack[mach_count-1];
    r.depth     = mach_count[8:0];
    r.exit_code = mach_exit;
    return r;
  endfunction

  // Random word with extra weight on zero, all ones, small values and single bits.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(0, 15));
      3:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Offers one instruction item, waits for acceptance and records its expected result.
  task automatic issue_instr(input logic [2:0] f, input logic [31:0] imm, input bit known,
                             input machine_result_t known_res, output status_e st);
    machine_result_t r;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    immediate_i <= imm;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    r = execute_instr(f, imm);
    pending_results.push_back(known ? known_res : r);
    items_sent++;
    if (r.status == ST_OVERFLOW) n_overflow++;
    if (r.status == ST_UNDERFLOW) n_underflow++;
    if (r.status == ST_HALTED) n_halted++;
    st = r.status;
  endtask

  task automatic row(input logic [2:0] f, input logic [31:0] imm);
    stim_row_t s;
    s.func  = f;
    s.imm   = imm;
    s.known = 1'b0;
    s.res   = '0;
    directed_rows.push_back(s);
  endtask

  task automatic row_known(input logic [2:0] f, input logic [31:0] imm, input status_e st,
                           input logic [31:0] top, input logic [8:0] depth,
                           input logic [7:0] code);
    stim_row_t s;
    s.func          = f;
    s.imm           = imm;
    s.known         = 1'b1;
    s.res.status    = st;
    s.res.top       = top;
    s.res.depth     = depth;
    s.res.exit_code = code;
    directed_rows.push_back(s);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever the sender asks for one.
  always @(posedge clk_i) begin
    if (holds_seen != hold_requests) begin
      holds_seen = hold_requests;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Result checker: every accepted result item is compared with the oldest expectation.
  always @(posedge clk_i) begin
    machine_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result item with nothing expected, status %0d top %h", $time,
                 status_o, top_value_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
          mismatches++;
        end
        if (top_value_o !== want.top) begin
          $display("%0t: top_value expected %h, got %h", $time, want.top, top_value_o);
          mismatches++;
        end
        if (stack_depth_o !== want.depth) begin
          $display("%0t: stack_depth expected %0d, got %0d", $time, want.depth, stack_depth_o);
          mismatches++;
        end
        if (exit_code_o !== want.exit_code) begin
          $display("%0t: exit_code expected %0d, got %0d", $time, want.exit_code,
                   exit_code_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run if no item moves on either channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog expired, %0d results still outstanding", $time,
             pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  // Main stimulus.
  initial begin
    logic [2:0]  f;
    status_e     st;
    int unsigned pick;
    int unsigned hits;
    bit          filling;

    mach_count   = 0;
    mach_exit    = EXIT_AT_RESET;
    mach_running = 1'b1;
    filling      = 1'b1;
    hits         = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: empty-stack errors, spare codes, wrap-around arithmetic.
    row_known(OP_ADD,     32'h0000_0000, ST_UNDERFLOW, 32'h0, 9'd0, EXIT_AT_RESET);
    row_known(OP_SUB,     32'hFFFF_FFFF, ST_UNDERFLOW, 32'h0, 9'd0, EXIT_AT_RESET);
    row_known(OP_MUL,     32'h0000_0000, ST_UNDERFLOW, 32'h0, 9'd0, EXIT_AT_RESET);
    row_known(OP_HALT,    32'hFFFF_FFFF, ST_UNDERFLOW, 32'h0, 9'd0, EXIT_AT_RESET);
    row_known(OP_SPARE_5, 32'hFFFF_FFFF, ST_EXECUTED,  32'h0, 9'd0, EXIT_AT_RESET);
    row_known(OP_PUSH,    32'hFFFF_FFFF, ST_EXECUTED,  32'hFFFF_FFFF, 9'd1, EXIT_AT_RESET);
    row_known(OP_MUL,     32'h0000_0000, ST_UNDERFLOW, 32'hFFFF_FFFF, 9'd1, EXIT_AT_RESET);
    row_known(OP_PUSH,    32'h0000_0001, ST_EXECUTED,  32'h1, 9'd2, EXIT_AT_RESET);
    row_known(OP_ADD,     32'h0000_0000, ST_EXECUTED,  32'h0, 9'd1, EXIT_AT_RESET);
    row(OP_PUSH,    32'hFFFF_FFFF);
    row(OP_PUSH,    32'hFFFF_FFFF);
    row(OP_MUL,     32'h1234_5678);
    row(OP_PUSH,    32'h0000_0004);
    row(OP_PUSH,    32'h0000_0003);
    row(OP_SUB,     32'h0000_0000);
    row(OP_SPARE_6, 32'hAAAA_AAAA);
    row(OP_SPARE_7, 32'h5555_5555);
    row(OP_PUSH,    32'h8000_0000);
    row(OP_PUSH,    32'h8000_0000);
    row(OP_ADD,     32'hFFFF_FFFF);
    row(OP_PUSH,    32'h0001_0000);
    row(OP_PUSH,    32'h0001_0000);
    row(OP_MUL,     32'h0000_0000);
    row(OP_SUB,     32'hDEAD_BEEF);
    foreach (directed_rows[i]) begin
      issue_instr(directed_rows[i].func, directed_rows[i].imm, directed_rows[i].known,
                  directed_rows[i].res, st);
    end

    // Random phases: the stack is filled to overflow and drained to underflow in turn.
    for (int phase = 0; phase < 4; phase++) begin
      in_valid_i <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      // A long receiver hold-off while the sender keeps offering items.
      if (phase == 0) hold_requests++;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          case ($urandom_range(0, 2))
            0:       f = OP_SPARE_5;
            1:       f = OP_SPARE_6;
            default: f = OP_SPARE_7;
          endcase
        end else if (pick < 7) begin
          // Halt only on an empty stack here, so the machine keeps running.
          f = (mach_count == 0) ? OP_HALT : OP_MUL;
        end else if (filling ? (pick < 91) : (pick < 13)) begin
          f = OP_PUSH;
        end else begin
          case ($urandom_range(0, 2))
            0:       f = OP_ADD;
            1:       f = OP_SUB;
            default: f = OP_MUL;
          endcase
        end
        issue_instr(f, rand_word(), 1'b0, '0, st);
        if (filling && st == ST_OVERFLOW) hits++;
        if (!filling && st == ST_UNDERFLOW) hits++;
        if (hits >= 3) begin
          filling = !filling;
          hits    = 0;
        end
      end
    end

    // Closing sequence: a real halt, then items that find the machine stopped.
    issue_instr(OP_PUSH, rand_word(), 1'b0, '0, st);
    issue_instr(OP_HALT, rand_word(), 1'b0, '0, st);
    issue_instr(OP_PUSH, 32'hFFFF_FFFF, 1'b0, '0, st);
    issue_instr(OP_ADD, rand_word(), 1'b0, '0, st);
    issue_instr(OP_HALT, rand_word(), 1'b0, '0, st);
    issue_instr(OP_SPARE_7, rand_word(), 1'b0, '0, st);
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);

    $display("Ran %0d instructions over four handshake phases, %0d results checked.",
             items_sent, results_checked);
    $display("Saw %0d overflow and %0d underflow items; halted %0d time(s), exit code %0d.",
             n_overflow, n_underflow, n_halted, mach_exit);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
